// ----- rtl/sfr_pkg.sv -----
// Shared types and constants of the SBUS frame receiver.
// Used by every module of the receiver; depends on nothing else.
`default_nettype none

package sfr_pkg;

  localparam int COUNT_WIDTH_DEF = 32;
  localparam int RESULT_COUNT_W  = 32;
  localparam int BYTE_W          = 8;
  localparam int CHAN_W          = 11;
  localparam int INDEX_W         = 5;
  localparam int POS_W           = 5;
  localparam int STORE_LEN       = 23;
  localparam int PAYLOAD_LEN     = 22;
  localparam int PAYLOAD_W       = PAYLOAD_LEN * BYTE_W;
  localparam int ANALOG_CHANS    = 16;
  localparam int QUEUE_DEPTH     = 2;

  localparam logic [BYTE_W-1:0]  START_BYTE  = 8'h0F;
  localparam logic [BYTE_W-1:0]  END_BYTE    = 8'h00;
  localparam logic [CHAN_W-1:0]  DIGITAL_ON  = 11'h7FF;
  localparam logic [CHAN_W-1:0]  DIGITAL_OFF = 11'h000;
  localparam logic [POS_W-1:0]   POS_IDLE    = 5'd0;
  localparam logic [POS_W-1:0]   POS_END     = 5'd24;
  localparam logic [INDEX_W-1:0] DIGITAL_CH0 = 5'd16;
  localparam logic [INDEX_W-1:0] LAST_CH     = 5'd17;

  localparam logic STATUS_GOOD  = 1'b0;
  localparam logic STATUS_ERROR = 1'b1;

  typedef struct packed {
    logic                      is_error;
    logic                      failsafe;
    logic                      lost;
    logic [1:0]                digital;
    logic [PAYLOAD_W-1:0]      payload;
    logic [RESULT_COUNT_W-1:0] good_cnt;
    logic [RESULT_COUNT_W-1:0] lost_cnt;
    logic [RESULT_COUNT_W-1:0] error_cnt;
  } sfr_entry_t;

endpackage

`default_nettype wire

// ----- rtl/sfr_front.sv -----
// Front end: tracks the byte position, gathers the frame bytes, checks the end byte
// and keeps the frame counters. Depends on sfr_pkg.
`default_nettype none

module sfr_front #(
  parameter int COUNT_WIDTH = sfr_pkg::COUNT_WIDTH_DEF
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       rx_valid,
  output logic                            rx_stall,
  input  wire logic [sfr_pkg::BYTE_W-1:0] rx_byte,
  input  wire logic                       q_full,
  output logic                            q_push,
  output sfr_pkg::sfr_entry_t             q_entry
);
  import sfr_pkg::*;

  logic [POS_W-1:0]       position;
  logic [POS_W-1:0]       position_next;
  logic [BYTE_W-1:0]      store [STORE_LEN];
  logic [COUNT_WIDTH-1:0] good_frames;
  logic [COUNT_WIDTH-1:0] lost_frames;
  logic [COUNT_WIDTH-1:0] error_frames;
  logic [COUNT_WIDTH-1:0] good_frames_next;
  logic [COUNT_WIDTH-1:0] lost_frames_next;
  logic [COUNT_WIDTH-1:0] error_frames_next;
  logic                   accept;
  logic                   at_end;
  logic                   bad_end;
  logic [BYTE_W-1:0]      flags;

  assign at_end   = (position == POS_END);
  assign rx_stall = at_end && q_full;
  assign accept   = rx_valid && !rx_stall;
  assign bad_end  = (rx_byte != END_BYTE);
  assign q_push   = accept && at_end;
  assign flags    = store[STORE_LEN-1];

  always_comb begin
    if (position == POS_IDLE) begin
      position_next = (rx_byte == START_BYTE) ? POS_W'(1) : POS_IDLE;
    end else if (position < POS_END) begin
      position_next = position + POS_W'(1);
    end else begin
      position_next = POS_IDLE;
    end
  end

  always_comb begin
    good_frames_next  = good_frames;
    lost_frames_next  = lost_frames;
    error_frames_next = error_frames;
    if (q_push) begin
      if (bad_end) begin
        error_frames_next = error_frames + COUNT_WIDTH'(1);
      end else begin
        good_frames_next = good_frames + COUNT_WIDTH'(1);
        if (flags[2]) begin
          lost_frames_next = lost_frames + COUNT_WIDTH'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      position     <= POS_IDLE;
      good_frames  <= '0;
      lost_frames  <= '0;
      error_frames <= '0;
    end else begin
      if (accept) begin
        position <= position_next;
      end
      good_frames  <= good_frames_next;
      lost_frames  <= lost_frames_next;
      error_frames <= error_frames_next;
    end
  end

  // The frame bytes shift in, so the first payload byte ends at the bottom.
  always_ff @(posedge clk) begin
    if (accept && (position != POS_IDLE) && !at_end) begin
      for (int i = 0; i < STORE_LEN - 1; i++) begin
        store[i] <= store[i+1];
      end
      store[STORE_LEN-1] <= rx_byte;
    end
  end

  always_comb begin
    q_entry.is_error  = bad_end;
    q_entry.failsafe  = flags[3];
    q_entry.lost      = flags[2];
    q_entry.digital   = flags[1:0];
    q_entry.good_cnt  = RESULT_COUNT_W'(good_frames_next);
    q_entry.lost_cnt  = RESULT_COUNT_W'(lost_frames_next);
    q_entry.error_cnt = RESULT_COUNT_W'(error_frames_next);
    for (int i = 0; i < PAYLOAD_LEN; i++) begin
      q_entry.payload[i*BYTE_W +: BYTE_W] = store[i];
    end
  end

endmodule

`default_nettype wire

// ----- rtl/sfr_queue.sv -----
// Short queue of finished frames between the front end and the result emitter.
// Depends on sfr_pkg.
`default_nettype none

module sfr_queue (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                push,
  input  wire sfr_pkg::sfr_entry_t entry_in,
  output logic                     full,
  input  wire logic                pop,
  output logic                     head_valid,
  output sfr_pkg::sfr_entry_t      head
);
  import sfr_pkg::*;

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  sfr_entry_t       slots [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] fill;
  logic             do_push;
  logic             do_pop;

  assign full       = (fill == CNT_W'(QUEUE_DEPTH));
  assign head_valid = (fill != '0);
  assign head       = slots[rd_ptr];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        fill <= fill + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        fill <= fill - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= entry_in;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/sfr_back.sv -----
// Result emitter: walks the channels of the frame at the head of the queue and
// drives the registered result port. Depends on sfr_pkg.
`default_nettype none

module sfr_back (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               head_valid,
  input  wire sfr_pkg::sfr_entry_t                head,
  output logic                                    pop,
  output logic                                    res_valid,
  input  wire logic                               res_stall,
  output logic                                    frame_status,
  output logic [sfr_pkg::INDEX_W-1:0]             channel_index,
  output logic [sfr_pkg::CHAN_W-1:0]              channel_value,
  output logic                                    failsafe,
  output logic                                    frame_lost,
  output logic [sfr_pkg::RESULT_COUNT_W-1:0]      good_count,
  output logic [sfr_pkg::RESULT_COUNT_W-1:0]      lost_count,
  output logic [sfr_pkg::RESULT_COUNT_W-1:0]      error_count,
  output logic                                    last
);
  import sfr_pkg::*;

  logic [INDEX_W-1:0] chan;
  logic               load;
  logic               final_one;
  logic [CHAN_W-1:0]  value;

  assign load      = head_valid && (!res_valid || !res_stall);
  assign final_one = head.is_error || (chan == LAST_CH);
  assign pop       = load && final_one;

  always_comb begin
    if (chan < DIGITAL_CH0) begin
      value = head.payload[chan[3:0]*CHAN_W +: CHAN_W];
    end else if (chan == DIGITAL_CH0) begin
      value = head.digital[0] ? DIGITAL_ON : DIGITAL_OFF;
    end else begin
      value = head.digital[1] ? DIGITAL_ON : DIGITAL_OFF;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      chan      <= '0;
      res_valid <= 1'b0;
    end else begin
      if (load) begin
        chan      <= final_one ? '0 : chan + INDEX_W'(1);
        res_valid <= 1'b1;
      end else if (!res_stall) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      good_count  <= head.good_cnt;
      lost_count  <= head.lost_cnt;
      error_count <= head.error_cnt;
      last        <= final_one;
      if (head.is_error) begin
        frame_status  <= STATUS_ERROR;
        channel_index <= '0;
        channel_value <= '0;
        failsafe      <= 1'b0;
        frame_lost    <= 1'b0;
      end else begin
        frame_status  <= STATUS_GOOD;
        channel_index <= chan;
        channel_value <= value;
        failsafe      <= head.failsafe;
        frame_lost    <= head.lost;
      end
    end
  end

endmodule

`default_nettype wire

// ----- rtl/sbus_frame_receiver_core.sv -----
// Top level of the SBUS frame receiver: front end, frame queue and result emitter.
// Depends on sfr_pkg, sfr_front, sfr_queue and sfr_back.
//
//   channel   ports                                   direction
//   rx        rx_valid, rx_stall, rx_byte             in
//   result    res_valid, res_stall, frame_status ...  out
//
// A byte is taken every cycle unless rx_stall is high; a frame of 25 bytes yields 18
// results, one per cycle unless res_stall is high, or one error result, written to
// the queue, then to the one result register; two frames may wait in the queue.
// Reset clears the position, the counters, the queue and the result valid flag.
// The receiver stalls only on an end byte while the queue is full.
`default_nettype none

module sbus_frame_receiver_core #(
  parameter int COUNT_WIDTH = sfr_pkg::COUNT_WIDTH_DEF
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               rx_valid,
  output logic                                    rx_stall,
  input  wire logic [sfr_pkg::BYTE_W-1:0]         rx_byte,
  output logic                                    res_valid,
  input  wire logic                               res_stall,
  output logic                                    frame_status,
  output logic [sfr_pkg::INDEX_W-1:0]             channel_index,
  output logic [sfr_pkg::CHAN_W-1:0]              channel_value,
  output logic                                    failsafe,
  output logic                                    frame_lost,
  output logic [sfr_pkg::RESULT_COUNT_W-1:0]      good_count,
  output logic [sfr_pkg::RESULT_COUNT_W-1:0]      lost_count,
  output logic [sfr_pkg::RESULT_COUNT_W-1:0]      error_count,
  output logic                                    last
);
  import sfr_pkg::*;

  logic       q_full;
  logic       q_push;
  sfr_entry_t q_entry;
  logic       q_pop;
  logic       q_head_valid;
  sfr_entry_t q_head;

  sfr_front #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .rx_valid (rx_valid),
    .rx_stall (rx_stall),
    .rx_byte  (rx_byte),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_entry  (q_entry)
  );

  sfr_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .entry_in   (q_entry),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_head_valid),
    .head       (q_head)
  );

  sfr_back u_back (
    .clk           (clk),
    .rst           (rst),
    .head_valid    (q_head_valid),
    .head          (q_head),
    .pop           (q_pop),
    .res_valid     (res_valid),
    .res_stall     (res_stall),
    .frame_status  (frame_status),
    .channel_index (channel_index),
    .channel_value (channel_value),
    .failsafe      (failsafe),
    .frame_lost    (frame_lost),
    .good_count    (good_count),
    .lost_count    (lost_count),
    .error_count   (error_count),
    .last          (last)
  );

endmodule

`default_nettype wire

// ----- rtl/sfr_checker.sv -----
// Port checker for the SBUS frame receiver, bound to the top level.
// Depends on sfr_pkg and sbus_frame_receiver_core.
`default_nettype none

module sfr_checker (
  input wire logic                               clk,
  input wire logic                               rst,
  input wire logic                               res_valid,
  input wire logic                               res_stall,
  input wire logic                               frame_status,
  input wire logic [sfr_pkg::INDEX_W-1:0]        channel_index,
  input wire logic [sfr_pkg::CHAN_W-1:0]         channel_value,
  input wire logic                               failsafe,
  input wire logic                               frame_lost,
  input wire logic [sfr_pkg::RESULT_COUNT_W-1:0] good_count,
  input wire logic [sfr_pkg::RESULT_COUNT_W-1:0] lost_count,
  input wire logic [sfr_pkg::RESULT_COUNT_W-1:0] error_count,
  input wire logic                               last
);
  import sfr_pkg::*;

  a_stalled_word_holds: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_stall |=> res_valid && $stable(channel_index)
      && $stable(channel_value) && $stable(frame_status) && $stable(last)
      && $stable(failsafe) && $stable(frame_lost) && $stable(good_count)
      && $stable(lost_count) && $stable(error_count))
    else $error("Stalled result word changed.");

  a_error_is_single: assert property (@(posedge clk) disable iff (rst)
    res_valid && (frame_status == STATUS_ERROR) |->
      last && (channel_index == '0) && (channel_value == '0) && !failsafe && !frame_lost)
    else $error("Error result is malformed.");

  a_last_on_final_channel: assert property (@(posedge clk) disable iff (rst)
    res_valid && (frame_status == STATUS_GOOD) |-> (last == (channel_index == LAST_CH)))
    else $error("Last flag does not match the final channel.");

  a_index_in_range: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> (channel_index <= LAST_CH))
    else $error("Channel index out of range.");

  a_digital_values: assert property (@(posedge clk) disable iff (rst)
    res_valid && (channel_index >= DIGITAL_CH0) |->
      (channel_value == DIGITAL_ON) || (channel_value == DIGITAL_OFF))
    else $error("Digital channel value is neither on nor off.");

endmodule

bind sbus_frame_receiver_core sfr_checker u_sfr_checker (.*);

`default_nettype wire

// ----- test/tb_sbus_frame_receiver_core.sv -----
// Self-checking testbench for sbus_frame_receiver_core: feeds byte streams with whole,
// broken and corrupted frames and checks every channel result against its own decoder.
// Depends on sfr_pkg and the receiver RTL.
`default_nettype none

module tb_sbus_frame_receiver_core;
  timeunit 1ns;
  timeprecision 1ps;

  import sfr_pkg::*;

  typedef struct {
    logic                      status;
    logic [INDEX_W-1:0]        index;
    logic [CHAN_W-1:0]         value;
    logic                      failsafe;
    logic                      lost;
    logic [RESULT_COUNT_W-1:0] good;
    logic [RESULT_COUNT_W-1:0] lost_cnt;
    logic [RESULT_COUNT_W-1:0] err_cnt;
    logic                      last;
  } chan_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic rx_valid = 1'b0;
  logic rx_stall;
  logic [BYTE_W-1:0] rx_byte = '0;
  logic res_valid;
  logic res_stall = 1'b0;
  logic frame_status;
  logic [INDEX_W-1:0] channel_index;
  logic [CHAN_W-1:0] channel_value;
  logic failsafe;
  logic frame_lost;
  logic [RESULT_COUNT_W-1:0] good_count;
  logic [RESULT_COUNT_W-1:0] lost_count;
  logic [RESULT_COUNT_W-1:0] error_count;
  logic last;

  sbus_frame_receiver_core dut (
    .clk(clk),
    .rst(rst),
    .rx_valid(rx_valid),
    .rx_stall(rx_stall),
    .rx_byte(rx_byte),
    .res_valid(res_valid),
    .res_stall(res_stall),
    .frame_status(frame_status),
    .channel_index(channel_index),
    .channel_value(channel_value),
    .failsafe(failsafe),
    .frame_lost(frame_lost),
    .good_count(good_count),
    .lost_count(lost_count),
    .error_count(error_count),
    .last(last)
  );

  logic [BYTE_W-1:0] pending_bytes[$];
  chan_result_t channel_expect_q[$];

  logic [POS_W-1:0] frame_pos = POS_IDLE;
  logic [BYTE_W-1:0] frame_bytes[STORE_LEN];
  logic [RESULT_COUNT_W-1:0] good_frames = '0;
  logic [RESULT_COUNT_W-1:0] lost_frames = '0;
  logic [RESULT_COUNT_W-1:0] error_frames = '0;

  int mismatches = 0;
  int bytes_taken = 0;
  int burst_left = 0;
  int gap_left = 0;
  int stall_mode = 0;
  int stall_span = 0;
  int cycle_no = 0;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  task automatic note_mismatch(input string msg);
    $display("mismatch at %0t ns: %s", $time, msg);
    mismatches++;
  endtask

  task automatic check_field(input string name, input logic [31:0] got,
                             input logic [31:0] want);
    if (got !== want) begin
      note_mismatch($sformatf("%s is %0h, expected %0h", name, got, want));
    end
  endtask

  task automatic decode_byte(input logic [BYTE_W-1:0] b);
    logic [PAYLOAD_W-1:0] payload;
    logic [BYTE_W-1:0] flags;
    chan_result_t r;
    if (frame_pos == POS_IDLE || frame_pos > POS_END) begin
      frame_pos = (b == START_BYTE) ? 5'd1 : POS_IDLE;
    end else if (frame_pos < POS_END) begin
      frame_bytes[frame_pos - 1] = b;
      frame_pos = frame_pos + 5'd1;
    end else begin
      frame_pos = POS_IDLE;
      if (b != END_BYTE) begin
        error_frames = error_frames + 1;
        r.status = STATUS_ERROR;
        r.index = '0;
        r.value = '0;
        r.failsafe = 1'b0;
        r.lost = 1'b0;
        r.good = good_frames;
        r.lost_cnt = lost_frames;
        r.err_cnt = error_frames;
        r.last = 1'b1;
        channel_expect_q.push_back(r);
      end else begin
        flags = frame_bytes[STORE_LEN - 1];
        for (int i = 0; i < PAYLOAD_LEN; i++) payload[8*i +: 8] = frame_bytes[i];
        if (flags[2]) lost_frames = lost_frames + 1;
        good_frames = good_frames + 1;
        for (int ch = 0; ch <= int'(LAST_CH); ch++) begin
          r.status = STATUS_GOOD;
          r.index = INDEX_W'(ch);
          if (ch < ANALOG_CHANS) r.value = payload[ch*CHAN_W +: CHAN_W];
          else r.value = flags[ch - int'(DIGITAL_CH0)] ? DIGITAL_ON : DIGITAL_OFF;
          r.failsafe = flags[3];
          r.lost = flags[2];
          r.good = good_frames;
          r.lost_cnt = lost_frames;
          r.err_cnt = error_frames;
          r.last = (ch == int'(LAST_CH));
          channel_expect_q.push_back(r);
        end
      end
    end
  endtask

  // Fill styles: 0 random, 1 all zero, 2 all ones, 3 start bytes throughout.
  task automatic queue_frame(input int fill, input logic [BYTE_W-1:0] flags,
                             input logic [BYTE_W-1:0] end_b);
    pending_bytes.push_back(START_BYTE);
    for (int i = 0; i < PAYLOAD_LEN; i++) begin
      case (fill)
        1: pending_bytes.push_back(8'h00);
        2: pending_bytes.push_back(8'hFF);
        3: pending_bytes.push_back(START_BYTE);
        default: pending_bytes.push_back(BYTE_W'($urandom_range(0, 255)));
      endcase
    end
    pending_bytes.push_back(flags);
    pending_bytes.push_back(end_b);
  endtask

  always @(posedge clk) begin
    if (rst) begin
      rx_valid <= 1'b0;
    end else if (!rx_valid || !rx_stall) begin
      if (gap_left != 0 || pending_bytes.size() == 0) begin
        rx_valid <= 1'b0;
        if (gap_left != 0) gap_left--;
      end else begin
        rx_valid <= 1'b1;
        rx_byte <= pending_bytes.pop_front();
        if (burst_left <= 1) begin
          burst_left = $urandom_range(1, 40);
          gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        end else begin
          burst_left--;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_no++;
    if (stall_span == 0) begin
      stall_mode = $urandom_range(0, 3);
      stall_span = $urandom_range(20, 80);
    end else begin
      stall_span--;
    end
    case (stall_mode)
      0: res_stall <= 1'b0;
      1: res_stall <= ($urandom_range(0, 1) == 1);
      2: res_stall <= ((cycle_no % 9) < 5);
      default: res_stall <= ($urandom_range(0, 7) == 0);
    endcase
  end

  always @(posedge clk) begin
    chan_result_t e;
    if (!rst) begin
      if (rx_valid && !rx_stall) begin
        decode_byte(rx_byte);
        bytes_taken++;
      end
      if (res_valid && !res_stall) begin
        if (channel_expect_q.size() == 0) begin
          note_mismatch($sformatf("unexpected result for channel %0d", channel_index));
        end else begin
          e = channel_expect_q.pop_front();
          check_field("frame_status", frame_status, e.status);
          check_field("channel_index", channel_index, e.index);
          check_field("channel_value", channel_value, e.value);
          check_field("failsafe", failsafe, e.failsafe);
          check_field("frame_lost", frame_lost, e.lost);
          check_field("good_count", good_count, e.good);
          check_field("lost_count", lost_count, e.lost_cnt);
          check_field("error_count", error_count, e.err_cnt);
          check_field("last", last, e.last);
        end
      end
    end
  end

  initial begin
    #2_000_000;
    $display("tb_sbus_frame_receiver_core: errors");
    $finish;
  end

  initial begin
    int total;
    int noise;
    int cut;
    pending_bytes.push_back(8'h00);
    pending_bytes.push_back(8'hFF);
    pending_bytes.push_back(8'h55);
    pending_bytes.push_back(8'hAA);
    queue_frame(2, 8'hFF, END_BYTE);
    queue_frame(3, 8'h00, 8'hFF);
    queue_frame(1, 8'h04, END_BYTE);
    while (pending_bytes.size() < 230) begin
      case ($urandom_range(0, 9))
        0: begin
          noise = $urandom_range(1, 5);
          repeat (noise) pending_bytes.push_back(BYTE_W'($urandom_range(0, 255)));
        end
        1: begin
          cut = $urandom_range(1, 23);
          pending_bytes.push_back(START_BYTE);
          repeat (cut) pending_bytes.push_back(BYTE_W'($urandom_range(0, 255)));
        end
        default: begin
          queue_frame(($urandom_range(0, 5) == 0) ? $urandom_range(1, 3) : 0,
                      BYTE_W'($urandom_range(0, 255)),
                      ($urandom_range(0, 4) == 0) ? BYTE_W'($urandom_range(1, 255))
                                                  : END_BYTE);
        end
      endcase
    end
    total = pending_bytes.size();
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    while (bytes_taken < total) @(posedge clk);
    while (channel_expect_q.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (mismatches == 0) begin
      $display("tb_sbus_frame_receiver_core: clean");
    end else begin
      $display("tb_sbus_frame_receiver_core: errors");
    end
    $finish;
  end

endmodule

`default_nettype wire
